@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define CHK_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle whenever the antecedent holds
`define CHK_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ src/stok_pkg.sv @@
// ----------------------------------------------------------------------------
// stok_pkg
// token codes, character classes and keyword table of the source tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

    // defaults of the top level parameters
    localparam int KEYWORD_MAX_CHARS_DEF = 9;
    localparam int LENGTH_BITS_DEF       = 12;
    localparam int POSITION_BITS_DEF     = 32;

    localparam int START_W   = 32;
    localparam int TYPE_W    = 5;
    // result word without the length field: kind, type, start, last
    localparam int REC_FIXED_W = 1 + TYPE_W + START_W + 1;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PUSH_MAX   = 3;

    // result kinds
    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // token codes
    localparam logic [TYPE_W-1:0] TOK_LITERAL = 5'd0;
    localparam logic [TYPE_W-1:0] TOK_LT      = 5'd17;
    localparam logic [TYPE_W-1:0] TOK_GT      = 5'd18;
    localparam logic [TYPE_W-1:0] TOK_ASSIGN  = 5'd25;
    localparam logic [TYPE_W-1:0] TOK_EQ      = 5'd26;
    localparam logic [TYPE_W-1:0] TOK_NE      = 5'd27;
    localparam logic [TYPE_W-1:0] TOK_LE      = 5'd30;
    localparam logic [TYPE_W-1:0] TOK_GE      = 5'd31;

    // characters
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;

    // keyword and symbol table, token code is index plus one
    localparam int KW_COUNT = 31;
    localparam int KW_CHARS = 9;

    // text is right aligned: char j of an n char word is byte n-1-j
    localparam logic [KW_CHARS-1:0][7:0] KW_TEXT [KW_COUNT] = '{
        "interface", "struct", "func", "for", "while", "return", "if",
        "+", "-", "*", "/", "'", "(", ")", "{", "}", "<", ">", "[", "]",
        ";", "?", ",", ":", "=", "==", "!=", ".", "static", "<=", ">="
    };

    localparam int KW_LEN [KW_COUNT] = '{
        9, 6, 4, 3, 5, 6, 2,
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
        1, 1, 1, 1, 1, 2, 2, 1, 6, 2, 2
    };

    // bytes that split tokens
    function automatic logic is_sep(input logic [7:0] c);
        is_sep = c inside {"/", "*", "+", "-", "<", ">", "(", ")", "{", "}",
                           "[", "]", ";", " ", 8'h09, "?", ",", ":", ".", "="};
    endfunction

    // printable ascii or newline
    function automatic logic is_printable(input logic [7:0] c);
        is_printable = (c inside {[8'h20:8'h7E]}) || (c == CH_NL);
    endfunction

endpackage

`default_nettype wire

@@ src/stok_classify.sv @@
// ----------------------------------------------------------------------------
// stok_classify
// matches a token prefix and length against the keyword and symbol table
// ----------------------------------------------------------------------------
`default_nettype none

module stok_classify #(
    parameter int KEYWORD_MAX_CHARS = stok_pkg::KEYWORD_MAX_CHARS_DEF,
    parameter int LENGTH_BITS       = stok_pkg::LENGTH_BITS_DEF
) (
    input  logic [KEYWORD_MAX_CHARS-1:0][7:0] prefix,
    input  logic [LENGTH_BITS-1:0]            length,
    output logic [stok_pkg::TYPE_W-1:0]       token_type
);
    import stok_pkg::*;

    logic hit;

    // all compares in parallel, words are distinct so at most one hits
    always_comb
    begin
        token_type = TOK_LITERAL;
        hit        = 1'b0;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            hit = (length == LENGTH_BITS'(KW_LEN[i]));
            for (int j = 0; j < KW_CHARS; j++)
            begin
                if (j < KW_LEN[i])
                begin
                    if (prefix[j] != KW_TEXT[i][KW_LEN[i]-1-j])
                    begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit)
            begin
                token_type = TYPE_W'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/stok_lexer.sv @@
// ----------------------------------------------------------------------------
// stok_lexer
// per byte token state update, held token merge and result word build
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stok_lexer #(
    parameter int KEYWORD_MAX_CHARS = stok_pkg::KEYWORD_MAX_CHARS_DEF,
    parameter int LENGTH_BITS       = stok_pkg::LENGTH_BITS_DEF,
    parameter int POSITION_BITS     = stok_pkg::POSITION_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            char_byte,
    input  logic                  end_of_input,
    output logic [stok_pkg::PUSH_MAX-1:0] push_v,
    output logic [stok_pkg::PUSH_MAX-1:0][LENGTH_BITS+stok_pkg::REC_FIXED_W-1:0] push_rec
);
    import stok_pkg::*;

    localparam int KM = KEYWORD_MAX_CHARS;
    localparam int LB = LENGTH_BITS;
    localparam int PB = POSITION_BITS;

    typedef struct packed {
        logic              valid;
        logic [TYPE_W-1:0] ttype;
        logic [PB-1:0]     start;
        logic [LB-1:0]     len;
        logic              bang;
    } held_t;

    function automatic logic merge_ok(input held_t h, input logic [TYPE_W-1:0] ty);
        merge_ok = h.valid && (ty == TOK_ASSIGN) &&
                   ((h.ttype == TOK_ASSIGN) || (h.ttype == TOK_LT) ||
                    (h.ttype == TOK_GT) || h.bang);
    endfunction

    function automatic logic [TYPE_W-1:0] merged_type(input held_t h);
        if (h.bang)
            merged_type = TOK_NE;
        else if (h.ttype == TOK_ASSIGN)
            merged_type = TOK_EQ;
        else if (h.ttype == TOK_LT)
            merged_type = TOK_LE;
        else
            merged_type = TOK_GE;
    endfunction

    logic [PB-1:0]           pos_reg, pos_next;
    logic [KM-1:0][7:0]      pre_reg, pre_next;
    logic [LB-1:0]           len_reg, len_next;
    logic [PB-1:0]           cur_start_reg, cur_start_next;
    held_t                   held_reg, held_next;
    logic                    discard_reg, discard_next;

    logic [TYPE_W-1:0]       type_a, type_b;
    logic                    c1, do_c1, do_c2, merge1, merge2;
    logic                    emit1, emit2, append, bang_a, bang_b;
    logic [LB-1:0]           len1, len2;
    logic [KM-1:0][7:0]      pre1, pre2;
    logic [PB-1:0]           start2;
    held_t                   h1, h2;

    // token in progress, and the token after this byte is appended
    stok_classify #(
        .KEYWORD_MAX_CHARS (KM),
        .LENGTH_BITS       (LB)
    ) u_class_a (
        .prefix     (pre_reg),
        .length     (len_reg),
        .token_type (type_a)
    );

    stok_classify #(
        .KEYWORD_MAX_CHARS (KM),
        .LENGTH_BITS       (LB)
    ) u_class_b (
        .prefix     (pre2),
        .length     (len2),
        .token_type (type_b)
    );

    always_comb
    begin
        // close on a separator or newline byte, or after a lone separator token
        c1     = ((len_reg == LB'(1)) && is_sep(pre_reg[0])) || is_sep(char_byte) ||
                 (char_byte == CH_NL);
        do_c1  = c1 && (len_reg != '0);
        bang_a = (len_reg == LB'(1)) && (pre_reg[0] == CH_BANG);
        merge1 = do_c1 && merge_ok(held_reg, type_a);
        emit1  = do_c1 && !merge1 && held_reg.valid;

        h1 = held_reg;
        if (merge1)
        begin
            h1.ttype = merged_type(held_reg);
            h1.start = pos_reg - PB'(2);
            h1.len   = LB'(2);
            h1.bang  = 1'b0;
        end
        else if (do_c1)
        begin
            h1.valid = 1'b1;
            h1.ttype = type_a;
            h1.start = cur_start_reg;
            h1.len   = len_reg;
            h1.bang  = bang_a;
        end

        len1 = c1 ? '0 : len_reg;
        pre1 = c1 ? '0 : pre_reg;

        // space and newline are dropped, everything else joins the token
        append = (char_byte != CH_SPACE) && (char_byte != CH_NL);
        start2 = (append && (len1 == '0)) ? pos_reg : cur_start_reg;
        pre2   = pre1;
        for (int i = 0; i < KM; i++)
        begin
            if (append && (len1 == LB'(i)))
            begin
                pre2[i] = char_byte;
            end
        end
        len2 = (append && (len1 != '1)) ? len1 + LB'(1) : len1;

        // end of text closes the grown token at the next position
        do_c2  = len2 != '0;
        bang_b = (len2 == LB'(1)) && (pre2[0] == CH_BANG);
        merge2 = do_c2 && merge_ok(h1, type_b);
        emit2  = do_c2 && !merge2 && h1.valid;

        h2 = h1;
        if (merge2)
        begin
            h2.ttype = merged_type(h1);
            h2.start = pos_reg - PB'(1);
            h2.len   = LB'(2);
            h2.bang  = 1'b0;
        end
        else if (do_c2)
        begin
            h2.valid = 1'b1;
            h2.ttype = type_b;
            h2.start = start2;
            h2.len   = len2;
            h2.bang  = bang_b;
        end

        push_rec[0] = {KIND_TOKEN, held_reg.ttype, START_W'(held_reg.start), held_reg.len, 1'b0};
        push_rec[1] = {KIND_TOKEN, h1.ttype, START_W'(h1.start), h1.len, 1'b0};
        push_rec[2] = {KIND_TOKEN, h2.ttype, START_W'(h2.start), h2.len, 1'b1};

        push_v         = '0;
        pos_next       = pos_reg;
        pre_next       = pre_reg;
        len_next       = len_reg;
        cur_start_next = cur_start_reg;
        held_next      = held_reg;
        discard_next   = discard_reg;

        if (accept)
        begin
            if (discard_reg)
            begin
                if (end_of_input)
                begin
                    pos_next       = '0;
                    pre_next       = '0;
                    len_next       = '0;
                    cur_start_next = '0;
                    held_next      = '0;
                    discard_next   = 1'b0;
                end
            end
            else if (!is_printable(char_byte))
            begin
                push_v[0]      = 1'b1;
                push_rec[0]    = {KIND_ERROR, TOK_LITERAL, START_W'(pos_reg), LB'(0), 1'b1};
                pos_next       = '0;
                pre_next       = '0;
                len_next       = '0;
                cur_start_next = '0;
                held_next      = '0;
                discard_next   = !end_of_input;
            end
            else if (end_of_input)
            begin
                push_v         = {h2.valid, emit2, emit1};
                pos_next       = '0;
                pre_next       = '0;
                len_next       = '0;
                cur_start_next = '0;
                held_next      = '0;
            end
            else
            begin
                push_v[0]      = emit1;
                pos_next       = pos_reg + PB'(1);
                pre_next       = pre2;
                len_next       = len2;
                cur_start_next = start2;
                held_next      = h1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            pre_reg       <= '0;
            len_reg       <= '0;
            cur_start_reg <= '0;
            held_reg      <= '0;
            discard_reg   <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            pre_reg       <= pre_next;
            len_reg       <= len_next;
            cur_start_reg <= cur_start_next;
            held_reg      <= held_next;
            discard_reg   <= discard_next;
        end
    end

    // while discarding, no token state survives
    `CHK_IMPLIES(a_discard_clean, discard_reg, !held_reg.valid && (len_reg == '0))
    // a held bang is always a lone literal byte
    `CHK_IMPLIES(a_bang_shape, held_reg.bang, (held_reg.ttype == TOK_LITERAL) && (held_reg.len == LB'(1)))

endmodule

`default_nettype wire

@@ src/stok_result_fifo.sv @@
// ----------------------------------------------------------------------------
// stok_result_fifo
// small result queue taking up to three words a cycle, giving one
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stok_result_fifo #(
    parameter int WIDTH = stok_pkg::REC_FIXED_W + stok_pkg::LENGTH_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [stok_pkg::PUSH_MAX-1:0]         push_v,
    input  logic [stok_pkg::PUSH_MAX-1:0][WIDTH-1:0] push_rec,
    output logic                                  room,
    input  logic                                  pop,
    output logic                                  head_valid,
    output logic [WIDTH-1:0]                      head
);
    import stok_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] mem [FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [1:0]       off2;
    logic [1:0]       total;
    logic [CW:0]      fill_sum;

    // words are packed in order behind the write pointer
    always_comb
    begin
        off2        = {1'b0, push_v[0]} + {1'b0, push_v[1]};
        total       = off2 + {1'b0, push_v[2]};
        fill_sum    = (CW+1)'(count_reg) + (CW+1)'(total);
        wr_ptr_next = wr_ptr_reg + PW'(total);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(total) - CW'(pop);
    end

    assign room       = count_reg <= CW'(FIFO_DEPTH - PUSH_MAX);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_v[0])
            mem[wr_ptr_reg] <= push_rec[0];
        if (push_v[1])
            mem[wr_ptr_reg + PW'(push_v[0])] <= push_rec[1];
        if (push_v[2])
            mem[wr_ptr_reg + PW'(off2)] <= push_rec[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // a burst never lands on unread words
    `CHK_ALWAYS(a_no_overflow, fill_sum <= (CW+1)'(FIFO_DEPTH))
    // only a stored word is taken
    `CHK_IMPLIES(a_no_underflow, pop, count_reg != '0)

endmodule

`default_nettype wire

@@ src/source_text_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// byte stream lexer: splits, classifies and merges tokens, flags bad bytes
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             word
// input     in         in_valid / in_ready   char_byte, end_of_input
// result    out        out_valid / out_ready result_kind, token_type,
//                                            token_start, token_length, last_token
//
// one byte is taken per cycle while the queue has room; the lexer state updates in the same cycle
// a byte yields zero to three words, the three only on the end of text byte
// results sit in a four word queue; a byte is taken while one or fewer wait,
// so with out_ready high the block keeps one byte and one word per cycle,
// apart from stalls while the queue drains after an end of text byte
// the first result word is visible the cycle after its byte is taken
// asynchronous reset empties the queue and clears all token state
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_top #(
    parameter int KEYWORD_MAX_CHARS = stok_pkg::KEYWORD_MAX_CHARS_DEF,
    parameter int LENGTH_BITS       = stok_pkg::LENGTH_BITS_DEF,
    parameter int POSITION_BITS     = stok_pkg::POSITION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // source bytes
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   char_byte,
    input  logic                         end_of_input,
    // result words
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         result_kind,
    output logic [stok_pkg::TYPE_W-1:0]  token_type,
    output logic [stok_pkg::START_W-1:0] token_start,
    output logic [LENGTH_BITS-1:0]       token_length,
    output logic                         last_token
);
    import stok_pkg::*;

    localparam int REC_W = LENGTH_BITS + REC_FIXED_W;

    logic                             accept;
    logic                             pop;
    logic [PUSH_MAX-1:0]              push_v;
    logic [PUSH_MAX-1:0][REC_W-1:0]   push_rec;
    logic [REC_W-1:0]                 head;

    // byte taken whenever the queue can absorb a worst case burst
    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;

    // token state, keyword match and merge of the held token
    stok_lexer #(
        .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS),
        .LENGTH_BITS       (LENGTH_BITS),
        .POSITION_BITS     (POSITION_BITS)
    ) u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_byte    (char_byte),
        .end_of_input (end_of_input),
        .push_v       (push_v),
        .push_rec     (push_rec)
    );

    // output queue, also the register between the two sides
    stok_result_fifo #(
        .WIDTH (REC_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_v     (push_v),
        .push_rec   (push_rec),
        .room       (in_ready),
        .pop        (pop),
        .head_valid (out_valid),
        .head       (head)
    );

    // word layout: kind, type, start, length, last
    assign {result_kind, token_type, token_start, token_length, last_token} = head;

endmodule

`default_nettype wire

@@ tb/source_text_tokenizer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_top_tb
// Feeds source texts byte by byte through the lexer and checks every result
// word against a predictor kept in step with each accepted byte. The run
// covers keywords, operator merges, near keywords, bad bytes, empty texts and
// random texts, with idle and stall phases on both channels.
// ----------------------------------------------------------------------------

module source_text_tokenizer_top_tb;

    import stok_pkg::*;

    localparam int KW_MAX   = KEYWORD_MAX_CHARS_DEF;
    localparam int LEN_MAX  = (1 << LENGTH_BITS_DEF) - 1;
    localparam logic [7:0] CH_TAB   = 8'h09;
    // top of the printable range
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // one expected result word
    typedef struct {
        logic                      kind;
        logic [TYPE_W-1:0]         tok_type;
        logic [START_W-1:0]        start;
        logic [LENGTH_BITS_DEF-1:0] length;
        logic                      last;
    } token_word_t;

    // dut ports, all known from time zero
    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_ready;
    logic [7:0]                  char_byte    = 8'h00;
    logic                        end_of_input = 1'b0;
    logic                        out_valid;
    logic                        out_ready    = 1'b0;
    logic                        result_kind;
    logic [TYPE_W-1:0]           token_type;
    logic [START_W-1:0]          token_start;
    logic [LENGTH_BITS_DEF-1:0]  token_length;
    logic                        last_token;

    // keyword and symbol spellings, token code is index plus one
    string kw_words [31] = '{
        "interface", "struct", "func", "for", "while", "return", "if",
        "+", "-", "*", "/", "'", "(", ")", "{", "}", "<", ">", "[", "]",
        ";", "?", ",", ":", "=", "==", "!=", ".", "static", "<=", ">="
    };
    string split_chars = "/*+-<>(){}[]; \t?,:.=";
    string ident_chars = "abcdefghijklmnopqrstuvwxyz0123456789_";

    // lexer state as predicted
    logic [START_W-1:0]  lex_pos;
    byte unsigned        cur_chars [KW_MAX];
    int                  cur_len;
    logic [START_W-1:0]  cur_start;
    logic [TYPE_W-1:0]   held_type;
    logic [START_W-1:0]  held_start;
    int                  held_len;
    bit                  held_valid;
    bit                  held_bang;
    bit                  skip_to_end;

    token_word_t  token_words_due [$];
    byte unsigned text_bytes [$];
    int           err_count     = 0;
    int           in_idle_pct   = 0;
    int           out_stall_pct = 0;

    source_text_tokenizer_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_byte    (char_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .token_type   (token_type),
        .token_start  (token_start),
        .token_length (token_length),
        .last_token   (last_token)
    );

    always #5 clk = ~clk;

    // receiver back pressure, redrawn every cycle
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic void reset_lexer();
        int i;
        lex_pos = '0;
        for (i = 0; i < KW_MAX; i++)
            cur_chars[i] = 8'h00;
        cur_len     = 0;
        cur_start   = '0;
        held_type   = TOK_LITERAL;
        held_start  = '0;
        held_len    = 0;
        held_valid  = 1'b0;
        held_bang   = 1'b0;
        skip_to_end = 1'b0;
    endfunction

    function automatic void add_word(logic kind, logic [TYPE_W-1:0] t,
                                     logic [START_W-1:0] s, int len, logic last);
        token_word_t w;
        w.kind     = kind;
        w.tok_type = t;
        w.start    = s;
        w.length   = len[LENGTH_BITS_DEF-1:0];
        w.last     = last;
        token_words_due = {token_words_due, w};
    endfunction

    function automatic bit split_char(byte unsigned c);
        int i;
        for (i = 0; i < split_chars.len(); i++)
            if (split_chars[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    // keyword lookup on the current token; anything longer than every keyword is a literal
    function automatic logic [TYPE_W-1:0] classify_current();
        int i;
        int j;
        bit same;
        if (cur_len > KW_MAX)
            return TOK_LITERAL;
        for (i = 0; i < 31; i++)
        begin
            if (kw_words[i].len() == cur_len)
            begin
                same = 1'b1;
                for (j = 0; j < cur_len; j++)
                    if (cur_chars[j] != kw_words[i][j])
                        same = 1'b0;
                if (same)
                    return TYPE_W'(i + 1);
            end
        end
        return TOK_LITERAL;
    endfunction

    // close the current token; a held = ! < > followed by = merges into one
    function automatic void close_current(logic [START_W-1:0] at_pos);
        logic [TYPE_W-1:0] t;
        bit bang;
        int i;
        if (cur_len == 0)
            return;
        t    = classify_current();
        bang = (cur_len == 1 && cur_chars[0] == CH_BANG);
        if (held_valid && t == TOK_ASSIGN && (held_type == TOK_ASSIGN ||
            held_type == TOK_LT || held_type == TOK_GT || held_bang))
        begin
            if (held_bang)
                held_type = TOK_NE;
            else if (held_type == TOK_ASSIGN)
                held_type = TOK_EQ;
            else if (held_type == TOK_LT)
                held_type = TOK_LE;
            else
                held_type = TOK_GE;
            held_start = at_pos - 32'd2;
            held_len   = 2;
            held_bang  = 1'b0;
        end
        else
        begin
            if (held_valid)
                add_word(KIND_TOKEN, held_type, held_start, held_len, 1'b0);
            held_valid = 1'b1;
            held_type  = t;
            held_start = cur_start;
            held_len   = cur_len;
            held_bang  = bang;
        end
        cur_len = 0;
        for (i = 0; i < KW_MAX; i++)
            cur_chars[i] = 8'h00;
    endfunction

    // advance the predicted lexer by one accepted byte
    function automatic void lex_byte(byte unsigned c, bit eoi);
        logic [START_W-1:0] at;
        at = lex_pos;
        if (skip_to_end)
        begin
            if (eoi)
                reset_lexer();
            return;
        end
        if (!((c >= CH_SPACE && c <= CH_TILDE) || c == CH_NL))
        begin
            add_word(KIND_ERROR, TOK_LITERAL, at, 0, 1'b1);
            reset_lexer();
            if (!eoi)
                skip_to_end = 1'b1;
            return;
        end
        if ((cur_len == 1 && split_char(cur_chars[0])) || split_char(c) || c == CH_NL)
            close_current(at);
        if (c != CH_SPACE && c != CH_TAB && c != CH_NL)
        begin
            if (cur_len == 0)
                cur_start = at;
            if (cur_len < KW_MAX)
                cur_chars[cur_len] = c;
            if (cur_len < LEN_MAX)
                cur_len++;
        end
        lex_pos = at + 32'd1;
        if (eoi)
        begin
            close_current(lex_pos);
            if (held_valid)
                add_word(KIND_TOKEN, held_type, held_start, held_len, 1'b1);
            reset_lexer();
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // every accepted word must match the oldest expectation, field by field
    always @(posedge clk)
    begin : result_check
        token_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (token_words_due.size() == 0)
            begin
                $display("%0t: word with none expected, expected none, actual %0h %0h %0h %0h %0h",
                         $time, result_kind, token_type, token_start, token_length,
                         last_token);
                err_count++;
            end
            else
            begin
                want = token_words_due.pop_front();
                check_field("result_kind",  32'(want.kind),     32'(result_kind));
                check_field("token_type",   32'(want.tok_type), 32'(token_type));
                check_field("token_start",  want.start,         token_start);
                check_field("token_length", 32'(want.length),   32'(token_length));
                check_field("last_token",   32'(want.last),     32'(last_token));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // one byte over the input channel; valid stays up after the handshake so
    // back to back words need no extra nonblocking update in the same step
    task automatic send_byte(byte unsigned c, bit eoi);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        char_byte    <= c;
        end_of_input <= eoi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lex_byte(c, eoi);
    endtask

    function automatic void add_byte(byte unsigned b);
        text_bytes = {text_bytes, b};
    endfunction

    function automatic void add_str(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    // send the built text, end of input flagged on its last byte
    task automatic send_text();
        int i;
        for (i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        text_bytes.delete();
    endtask

    // drop valid and wait for all predicted words, then idle before the next test
    task automatic drain();
        in_valid <= 1'b0;
        while (token_words_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // every keyword and symbol once; literals keep lone '<' '>' '=' apart
    task automatic test_keywords();
        add_str("interface struct func for while return if static");
        add_str("+-*/'(){}[];?,:.<a>a=a==!=<=>=");
        send_text();
        drain();
    endtask

    // operator merges across whitespace and newline, and near misses
    task automatic test_merges();
        add_str("x = \n= y ! = ===<<=");
        send_text();
        // bang left held at the end of text
        add_str("q !");
        send_text();
        drain();
    endtask

    // literals one byte past the keyword width and one byte short of a keyword
    task automatic test_long_token();
        add_str("interfaces interfac");
        send_text();
        drain();
    endtask

    // unprintable bytes: mid text with discard, and on the last byte
    task automatic test_bad_bytes();
        add_str("ab");
        add_byte(8'h01);
        add_str("cd ef");
        send_text();
        add_str("a");
        add_byte(8'h7F);
        send_text();
        add_byte(8'hFF);
        send_text();
        add_str("w ");
        add_byte(CH_TAB);
        add_str("v");
        send_text();
        // lexer is back to normal after the discard
        add_str("if");
        send_text();
        drain();
    endtask

    // texts that hold no token give no word
    task automatic test_empty_text();
        add_str("  ");
        send_text();
        add_byte(CH_NL);
        send_text();
        add_str("z");
        send_text();
        drain();
    endtask

    // random texts, mostly well formed fragments with some noise
    task automatic test_random(int idle_pct, int stall_pct, int n_bytes);
        int sent;
        int n_frag;
        int f;
        int k;
        byte unsigned c;
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        sent          = 0;
        while (sent < n_bytes)
        begin
            n_frag = $urandom_range(2, 4);
            for (f = 0; f < n_frag; f++)
            begin
                case ($urandom_range(0, 9))
                    0, 1: add_str(kw_words[$urandom_range(0, 30)]);
                    2, 3:
                    begin
                        for (k = $urandom_range(1, 8); k > 0; k--)
                            add_byte(ident_chars[$urandom_range(0, ident_chars.len() - 1)]);
                    end
                    4: add_str(kw_words[$urandom_range(24, 30)]);
                    5:
                    begin
                        c = split_chars[$urandom_range(0, split_chars.len() - 1)];
                        // tab counts as unprintable, keep it for the noise arm
                        add_byte(c == CH_TAB ? CH_BANG : c);
                    end
                    6, 7:
                    begin
                        for (k = $urandom_range(1, 3); k > 0; k--)
                            add_byte($urandom_range(0, 1) ? CH_SPACE : CH_NL);
                    end
                    8: add_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
                    default:
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            if ($urandom_range(0, 1))
                                c = 8'($urandom_range(8'h7F, 8'hFF));
                            else
                            begin
                                c = 8'($urandom_range(8'h00, 8'h1F));
                                if (c == CH_NL)
                                    c = 8'h00;
                            end
                            add_byte(c);
                        end
                        else
                            add_byte(CH_SPACE);
                    end
                endcase
            end
            sent += text_bytes.size();
            send_text();
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------

    initial
    begin
        reset_lexer();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_keywords();
        test_merges();
        test_long_token();
        test_bad_bytes();
        test_empty_text();

        // no idling, sender idle, receiver stalling, then both lightly
        test_random(0, 0, 6);
        test_random(52, 0, 6);
        test_random(0, 52, 6);
        test_random(10, 10, 6);

        if (err_count == 0)
            $display("source_text_tokenizer_top_tb: done, clean");
        else
            $display("source_text_tokenizer_top_tb: done, errors");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("source_text_tokenizer_top_tb: done, errors");
        $finish;
    end

endmodule
